[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro expects signals named clk and rst_n where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/bpmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery power-mode controller package
// Widths, register indexes, reset values, mode codes and the tracking record.
// ----------------------------------------------------------------------------
package bpmc_pkg;

  localparam int TIME_W      = 32;
  localparam int SAMPLE_W    = 16;
  localparam int NUM_SAMPLES = 7;
  localparam int MEDIAN_RANK = NUM_SAMPLES / 2;
  localparam int RANK_W      = $clog2(NUM_SAMPLES);
  localparam int CODE_W      = 15;
  localparam int GRACE_W     = 16;
  localparam int PERSIST_W   = 20;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRIT_ENTER = 2'd0,
    CFG_CRIT_EXIT  = 2'd1,
    CFG_GRACE      = 2'd2,
    CFG_PERSIST    = 2'd3
  } cfg_idx_t;

  // Register reset values.
  localparam logic [CODE_W-1:0]    CRIT_ENTER_RST = 15'd16500;
  localparam logic [CODE_W-1:0]    CRIT_EXIT_RST  = 15'd17000;
  localparam logic [GRACE_W-1:0]   GRACE_RST      = 16'd1000;
  localparam logic [PERSIST_W-1:0] PERSIST_RST    = 20'd30000;

  // Power mode state, one-hot.
  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'b001,
    MODE_SAVING   = 3'b010,
    MODE_CRITICAL = 3'b100
  } mode_t;

  // Mode codes as presented on the result channel.
  localparam logic [MODE_W-1:0] MODE_CODE_NORMAL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_SAVING   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_CRITICAL = 2'd2;

  // Mode and time-accounting state.
  typedef struct packed {
    mode_t             mode;
    logic              entry_valid;
    logic [TIME_W-1:0] entry_time;
    logic [TIME_W-1:0] normal_total;
    logic [TIME_W-1:0] saving_total;
    logic [TIME_W-1:0] critical_total;
    logic [TIME_W-1:0] crit_start;
  } track_t;

  localparam track_t TRACK_RST = '{
    mode:           MODE_NORMAL,
    entry_valid:    1'b0,
    entry_time:     '0,
    normal_total:   '0,
    saving_total:   '0,
    critical_total: '0,
    crit_start:     '0
  };

endpackage

[rtl/bpmc_channel_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery power-mode controller channels
// Valid/ready interfaces for the tick input, the result output and the
// configuration write port.
// ----------------------------------------------------------------------------

// Supervision tick channel.
interface bpmc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [bpmc_pkg::TIME_W-1:0]   now_ms;
  logic                                 power_good;
  logic                                 low_batt;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] sample_a;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] sample_b;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] sample_c;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] sample_d;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] sample_e;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] sample_f;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] sample_g;

  modport source (
    output valid, now_ms, power_good, low_batt,
    output sample_a, sample_b, sample_c, sample_d, sample_e, sample_f, sample_g,
    input  ready
  );
  modport sink (
    input  valid, now_ms, power_good, low_batt,
    input  sample_a, sample_b, sample_c, sample_d, sample_e, sample_f, sample_g,
    output ready
  );
endinterface

// Result channel.
interface bpmc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [bpmc_pkg::MODE_W-1:0]   mode;
  logic                                 mains_present;
  logic                                 deep_sleep_req;
  logic signed [bpmc_pkg::SAMPLE_W-1:0] median_code;
  logic        [bpmc_pkg::TIME_W-1:0]   time_normal_ms;
  logic        [bpmc_pkg::TIME_W-1:0]   time_saving_ms;
  logic        [bpmc_pkg::TIME_W-1:0]   time_critical_ms;

  modport source (
    output valid, mode, mains_present, deep_sleep_req, median_code,
    output time_normal_ms, time_saving_ms, time_critical_ms,
    input  ready
  );
  modport sink (
    input  valid, mode, mains_present, deep_sleep_req, median_code,
    input  time_normal_ms, time_saving_ms, time_critical_ms,
    output ready
  );
endinterface

// Configuration write channel.
interface bpmc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bpmc_pkg::CFG_IDX_W-1:0]    index;
  logic [bpmc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/battery_power_mode_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery power-mode controller
// Median filter, power-good debounce, three-mode supervisor with time
// accounting and deep-sleep request.
// ----------------------------------------------------------------------------
// The block accepts one supervision tick per clock cycle while the output is
// not stalled and presents one result for each tick: the tick is captured in an
// input register, and a single registered pass through the seven-way rank
// median and the mode logic loads the result register and the mode state at
// the same edge, so the mode state is always current for the next tick. A
// result waiting on a stalled output does not block input until the input
// register is also full. Configuration writes are taken at any time with
// ready held high and should be made while the block is idle. There is no
// clearing pass after reset.
`include "assert_macros.svh"

module battery_power_mode_controller_unit (
  input  logic         clk,
  input  logic         rst_n,
  bpmc_in_if.sink      in_if,
  bpmc_out_if.source   out_if,
  bpmc_cfg_if.sink     cfg_if
);

  localparam int TW = bpmc_pkg::TIME_W;
  localparam int SW = bpmc_pkg::SAMPLE_W;
  localparam int NS = bpmc_pkg::NUM_SAMPLES;

  // Configuration registers.
  logic [bpmc_pkg::CODE_W-1:0]    crit_enter_r;
  logic [bpmc_pkg::CODE_W-1:0]    crit_exit_r;
  logic [bpmc_pkg::GRACE_W-1:0]   grace_r;
  logic [bpmc_pkg::PERSIST_W-1:0] persist_r;

  // Input stage.
  logic                  s1_valid_r;
  logic [TW-1:0]         s1_now_r;
  logic                  s1_pg_r;
  logic                  s1_lb_r;
  logic signed [SW-1:0]  s1_samp_r [NS];

  // Supervisor state.
  bpmc_pkg::track_t      trk_r;
  bpmc_pkg::track_t      trk_nxt;
  logic                  mains_r;
  logic                  mains_nxt;
  logic [TW-1:0]         last_pg_r;
  logic [TW-1:0]         last_pg_nxt;

  // Result stage.
  logic                        out_valid_r;
  logic [bpmc_pkg::MODE_W-1:0] out_mode_r;
  logic [bpmc_pkg::MODE_W-1:0] out_mode_nxt;
  logic                        out_mains_r;
  logic                        out_sleep_r;
  logic                        out_sleep_nxt;
  logic signed [SW-1:0]        out_median_r;
  logic signed [SW-1:0]        median_nxt;
  logic [TW-1:0]               out_normal_r;
  logic [TW-1:0]               out_saving_r;
  logic [TW-1:0]               out_critical_r;

  // Handshake.
  logic advance;
  logic in_ready;
  logic s1_fire;

  assign advance  = !out_valid_r || out_if.ready;
  assign in_ready = !s1_valid_r || advance;
  assign s1_fire  = s1_valid_r && advance;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  // Account the span of the mode being left and enter the new mode.
  function automatic bpmc_pkg::track_t change_mode(input bpmc_pkg::track_t s,
                                                   input bpmc_pkg::mode_t  nxt,
                                                   input logic [TW-1:0]    now);
    bpmc_pkg::track_t r;
    logic [TW-1:0]    span;
    r    = s;
    span = now - s.entry_time;
    if (s.entry_valid) begin
      case (s.mode)
        bpmc_pkg::MODE_NORMAL: r.normal_total = s.normal_total + span;
        bpmc_pkg::MODE_SAVING: r.saving_total = s.saving_total + span;
        default:               r.critical_total = s.critical_total + span;
      endcase
    end
    r.entry_time  = now;
    r.entry_valid = 1'b1;
    r.mode        = nxt;
    if (nxt == bpmc_pkg::MODE_CRITICAL) begin
      r.crit_start = now;
    end
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_enter_r <= bpmc_pkg::CRIT_ENTER_RST;
      crit_exit_r  <= bpmc_pkg::CRIT_EXIT_RST;
      grace_r      <= bpmc_pkg::GRACE_RST;
      persist_r    <= bpmc_pkg::PERSIST_RST;
    end else if (cfg_if.valid) begin
      case (bpmc_pkg::cfg_idx_t'(cfg_if.index))
        bpmc_pkg::CFG_CRIT_ENTER: crit_enter_r <= cfg_if.data[bpmc_pkg::CODE_W-1:0];
        bpmc_pkg::CFG_CRIT_EXIT:  crit_exit_r  <= cfg_if.data[bpmc_pkg::CODE_W-1:0];
        bpmc_pkg::CFG_GRACE:      grace_r      <= cfg_if.data[bpmc_pkg::GRACE_W-1:0];
        bpmc_pkg::CFG_PERSIST:    persist_r    <= cfg_if.data[bpmc_pkg::PERSIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: control part.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  // Input register: payload part.
  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      s1_now_r     <= in_if.now_ms;
      s1_pg_r      <= in_if.power_good;
      s1_lb_r      <= in_if.low_batt;
      s1_samp_r[0] <= in_if.sample_a;
      s1_samp_r[1] <= in_if.sample_b;
      s1_samp_r[2] <= in_if.sample_c;
      s1_samp_r[3] <= in_if.sample_d;
      s1_samp_r[4] <= in_if.sample_e;
      s1_samp_r[5] <= in_if.sample_f;
      s1_samp_r[6] <= in_if.sample_g;
    end
  end

  // Median by rank: ties are broken by position, so exactly one sample holds
  // the middle rank.
  always_comb begin
    logic [bpmc_pkg::RANK_W-1:0] rank;
    median_nxt = s1_samp_r[0];
    for (int i = 0; i < NS; i++) begin
      rank = '0;
      for (int j = 0; j < NS; j++) begin
        if ((s1_samp_r[j] < s1_samp_r[i]) || ((j < i) && (s1_samp_r[j] == s1_samp_r[i]))) begin
          rank = rank + 1'b1;
        end
      end
      if (rank == bpmc_pkg::RANK_W'(bpmc_pkg::MEDIAN_RANK)) begin
        median_nxt = s1_samp_r[i];
      end
    end
  end

  // Power-good debounce and mode machine.
  always_comb begin
    logic signed [SW-1:0] enter_thr;
    logic signed [SW-1:0] exit_thr;
    logic [TW-1:0]        since_pg;
    logic [TW-1:0]        crit_span;
    enter_thr   = signed'({1'b0, crit_enter_r});
    exit_thr    = signed'({1'b0, crit_exit_r});
    since_pg    = s1_now_r - last_pg_r;
    mains_nxt   = mains_r;
    last_pg_nxt = last_pg_r;
    if ((s1_pg_r != mains_r) && (since_pg > TW'(grace_r))) begin
      mains_nxt   = s1_pg_r;
      last_pg_nxt = s1_now_r;
    end

    trk_nxt = trk_r;
    if (!mains_nxt) begin
      case (trk_r.mode)
        bpmc_pkg::MODE_NORMAL: begin
          trk_nxt = change_mode(trk_nxt, bpmc_pkg::MODE_SAVING, s1_now_r);
        end
        bpmc_pkg::MODE_SAVING: begin
          if (median_nxt <= enter_thr) begin
            trk_nxt = change_mode(trk_nxt, bpmc_pkg::MODE_CRITICAL, s1_now_r);
          end
        end
        default: begin
          if (median_nxt >= exit_thr) begin
            trk_nxt = change_mode(trk_nxt, bpmc_pkg::MODE_SAVING, s1_now_r);
          end
        end
      endcase
      // Low battery forces critical while on battery.
      if (s1_lb_r && (trk_nxt.mode != bpmc_pkg::MODE_CRITICAL)) begin
        trk_nxt = change_mode(trk_nxt, bpmc_pkg::MODE_CRITICAL, s1_now_r);
      end
    end else if (trk_r.mode != bpmc_pkg::MODE_NORMAL) begin
      trk_nxt = change_mode(trk_nxt, bpmc_pkg::MODE_NORMAL, s1_now_r);
    end

    crit_span     = s1_now_r - trk_nxt.crit_start;
    out_sleep_nxt = (trk_nxt.mode == bpmc_pkg::MODE_CRITICAL) && !mains_nxt &&
                    (crit_span > TW'(persist_r));

    case (trk_nxt.mode)
      bpmc_pkg::MODE_NORMAL: out_mode_nxt = bpmc_pkg::MODE_CODE_NORMAL;
      bpmc_pkg::MODE_SAVING: out_mode_nxt = bpmc_pkg::MODE_CODE_SAVING;
      default:               out_mode_nxt = bpmc_pkg::MODE_CODE_CRITICAL;
    endcase
  end

  // Supervisor state update, one tick per pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r     <= bpmc_pkg::TRACK_RST;
      mains_r   <= 1'b1;
      last_pg_r <= '0;
    end else if (s1_fire) begin
      trk_r     <= trk_nxt;
      mains_r   <= mains_nxt;
      last_pg_r <= last_pg_nxt;
    end
  end

  // Result register: control part.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result register: payload part.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_mode_r     <= out_mode_nxt;
      out_mains_r    <= mains_nxt;
      out_sleep_r    <= out_sleep_nxt;
      out_median_r   <= median_nxt;
      out_normal_r   <= trk_nxt.normal_total;
      out_saving_r   <= trk_nxt.saving_total;
      out_critical_r <= trk_nxt.critical_total;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.mode             = out_mode_r;
  assign out_if.mains_present    = out_mains_r;
  assign out_if.deep_sleep_req   = out_sleep_r;
  assign out_if.median_code      = out_median_r;
  assign out_if.time_normal_ms   = out_normal_r;
  assign out_if.time_saving_ms   = out_saving_r;
  assign out_if.time_critical_ms = out_critical_r;

  // Checks on the block's own logic.
  `ASSERT_SAME(a_mode_onehot, 1'b1, $onehot(trk_r.mode))
  `ASSERT_SAME(a_sleep_only_crit_batt, out_valid_r && out_sleep_r,
               (out_mode_r == bpmc_pkg::MODE_CODE_CRITICAL) && !out_mains_r)
  `ASSERT_SAME(a_mains_means_normal, out_valid_r && out_mains_r,
               out_mode_r == bpmc_pkg::MODE_CODE_NORMAL)
  `ASSERT_NEXT(a_tick_held_on_stall, s1_valid_r && !advance, s1_valid_r && $stable(s1_now_r))

endmodule
